>>> rtl/core/kmss_pkg.sv
// shared constants and types for the k-median site selection block
`default_nettype none
package kmss_pkg;
    localparam int MAX_GRID_DEF   = 64;
    localparam int MAX_DEMAND_DEF = 128;
    localparam int MAX_SITES_DEF  = 16;
    localparam logic [13:0] TOTAL_MAX = 14'h3FFF;
    localparam logic [1:0] CODE_EMPTY  = 2'd0;
    localparam logic [1:0] CODE_DEMAND = 2'd1;
    localparam logic [1:0] CODE_SITE   = 2'd2;
    localparam logic [1:0] CODE_UNUSED = 2'd3;
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FEW      = 2'd1;
    localparam logic [1:0] ST_OVF      = 2'd2;
    localparam logic [0:0] REG_GRID    = 1'd0;
    localparam logic [0:0] REG_PICK    = 1'd1;
    localparam logic [7:0] NEAR_INIT   = 8'd255;

    // manhattan distance of two packed points
    function automatic logic [7:0] manhattan(input logic [11:0] a, input logic [11:0] b);
        logic [5:0] dr;
        logic [5:0] dc;
        dr = (a[11:6] > b[11:6]) ? a[11:6] - b[11:6] : b[11:6] - a[11:6];
        dc = (a[5:0] > b[5:0]) ? a[5:0] - b[5:0] : b[5:0] - a[5:0];
        return {2'b00, dr} + {2'b00, dc};
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/kmss_cell_if.sv
// input channel carrying one grid cell
`default_nettype none
interface kmss_cell_if;
    logic       valid;
    logic       ready;
    logic [1:0] cell_code;
    logic       last_cell;
    modport source(output valid, cell_code, last_cell, input ready);
    modport sink(input valid, cell_code, last_cell, output ready);
endinterface
`default_nettype wire

>>> rtl/core/kmss_result_if.sv
// output channel carrying one search result
`default_nettype none
interface kmss_result_if;
    logic        valid;
    logic        ready;
    logic [13:0] best_total;
    logic [1:0]  status;
    modport source(output valid, best_total, status, input ready);
    modport sink(input valid, best_total, status, output ready);
endinterface
`default_nettype wire

>>> rtl/core/kmss_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
`default_nettype none
module kmss_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [AW-1:0]             i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [AW-1:0]             i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/k_median_site_selection.sv
// top level: grid loader, subset sequencer and shared distance unit
// search: after the last cell the block visits all C(sites,pick) subsets, one
//   distance/compare unit stepping over every demand point and chosen site;
//   error results skip the search and go straight to the output state;
//   the search waits while an older result is held
// throughput: one cell per cycle, not ready from last cell until result registered
// reset: synchronous active low, clears counters and control; stores undefined
`default_nettype none
module k_median_site_selection #(
    parameter int MAX_GRID   = kmss_pkg::MAX_GRID_DEF,
    parameter int MAX_DEMAND = kmss_pkg::MAX_DEMAND_DEF,
    parameter int MAX_SITES  = kmss_pkg::MAX_SITES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [0:0]  i_cfg_index,
    input  wire  [6:0]  i_cfg_data,
    kmss_cell_if.sink     grid_cell,
    kmss_result_if.source result
);
    localparam int DW = $clog2(MAX_DEMAND) > 0 ? $clog2(MAX_DEMAND) : 1;
    localparam int SW = $clog2(MAX_SITES) > 0 ? $clog2(MAX_SITES) : 1;
    localparam int DCW = $clog2(MAX_DEMAND + 1);
    localparam int SCW = $clog2(MAX_SITES + 1);

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_INIT  = 6'b000010,
        S_RD    = 6'b000100,
        S_SITE  = 6'b001000,
        S_NEXT  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state      r_state;
    logic [6:0]  r_grid;
    logic [4:0]  r_pick;
    logic [11:0] r_pos;
    logic [5:0]  r_row, r_col;
    logic [DCW-1:0] r_dcnt;
    logic [SCW-1:0] r_scnt;
    logic        r_ovf;
    logic [SW-1:0] r_idx [MAX_SITES];
    logic [SCW-1:0] r_k;
    logic [13:0] r_best, r_sum;
    logic [7:0]  r_near;
    logic [DW-1:0] r_d;
    logic [SCW-1:0] r_j;
    logic [11:0] r_site [MAX_SITES];
    logic [13:0] r_out_total;
    logic [1:0]  r_out_status;
    logic        r_out_valid;

    // clamped registers
    logic [6:0] w_g;
    logic [SCW-1:0] w_k;
    always_comb begin
        w_g = (r_grid == 7'd0) ? 7'd1 : (r_grid > 7'(MAX_GRID)) ? 7'(MAX_GRID) : r_grid;
        w_k = (r_pick == 5'd0) ? SCW'(1)
            : (32'(r_pick) > MAX_SITES) ? SCW'(MAX_SITES) : SCW'(r_pick);
    end

    logic w_in_tr, w_in_grid, w_dem_we;
    logic [11:0] w_g2;
    assign w_in_tr   = grid_cell.valid && grid_cell.ready;
    assign w_g2      = 12'(w_g) * 12'(w_g) - 12'd1;
    assign w_in_grid = (r_pos <= w_g2) && !(w_g == 7'd64 && 1'b0);
    assign grid_cell.ready = (r_state == S_LOAD);
    assign w_dem_we = w_in_tr && w_in_grid && grid_cell.cell_code == kmss_pkg::CODE_DEMAND
                      && 32'(r_dcnt) < MAX_DEMAND;

    // demand store
    logic [11:0] w_dem_rd;
    kmss_ram #(.WIDTH(12), .DEPTH(MAX_DEMAND)) u_dem (
        .i_clk(i_clk), .i_we(w_dem_we), .i_waddr(r_dcnt[DW-1:0]),
        .i_wdata({r_row, r_col}), .i_raddr(r_d), .o_rdata(w_dem_rd)
    );

    // shared distance unit
    logic [7:0] w_dist;
    logic [SW-1:0] w_jx;
    assign w_jx = r_j[SW-1:0];
    assign w_dist = kmss_pkg::manhattan(w_dem_rd, r_site[r_idx[w_jx]]);

    // subset advance: find rightmost index that can move
    logic w_moved;
    logic [SW-1:0] w_pos;
    always_comb begin
        w_moved = 1'b0;
        w_pos = '0;
        for (int i = 0; i < MAX_SITES; i++) begin
            if (i < 32'(r_k) && 32'(r_idx[i]) < 32'(r_scnt) - 32'(r_k) + i) begin
                w_moved = 1'b1;
                w_pos = SW'(i);
            end
        end
    end

    logic [14:0] w_acc;
    assign w_acc = {1'b0, r_sum} + 15'(r_near);

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid <= 7'd5;
            r_pick <= 5'd1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == kmss_pkg::REG_GRID) r_grid <= i_cfg_data;
            else r_pick <= i_cfg_data[4:0];
        end
    end

    // load and search sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_pos <= '0; r_row <= '0; r_col <= '0;
            r_dcnt <= '0; r_scnt <= '0; r_ovf <= 1'b0;
            r_best <= kmss_pkg::TOTAL_MAX;
            r_out_valid <= 1'b0;
            r_k <= '0; r_j <= '0; r_d <= '0;
            for (int i = 0; i < MAX_SITES; i++) r_idx[i] <= '0;
        end else begin
            if (r_out_valid && result.ready) r_out_valid <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (w_in_tr) begin
                        if (w_in_grid) begin
                            if (grid_cell.cell_code == kmss_pkg::CODE_DEMAND) begin
                                if (32'(r_dcnt) < MAX_DEMAND) r_dcnt <= r_dcnt + 1'b1;
                                else r_ovf <= 1'b1;
                            end else if (grid_cell.cell_code == kmss_pkg::CODE_SITE) begin
                                if (32'(r_scnt) < MAX_SITES) begin
                                    r_site[r_scnt[SW-1:0]] <= {r_row, r_col};
                                    r_scnt <= r_scnt + 1'b1;
                                end else r_ovf <= 1'b1;
                            end
                        end
                        // row and column follow the position, back to origin on wrap
                        if (r_pos == 12'hFFF) begin
                            r_col <= '0; r_row <= '0;
                        end else if (w_in_grid) begin
                            if (7'(r_col) + 7'd1 >= w_g) begin
                                r_col <= '0; r_row <= r_row + 6'd1;
                            end else r_col <= r_col + 6'd1;
                        end
                        r_pos <= r_pos + 12'd1;
                        if (grid_cell.last_cell) begin
                            r_k <= w_k;
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    // hold off while the previous result still waits
                    if (r_out_valid) begin
                        r_state <= S_INIT;
                    end else if (r_ovf) begin
                        r_out_total <= '0; r_out_status <= kmss_pkg::ST_OVF;
                        r_state <= S_OUT;
                    end else if (r_scnt < r_k) begin
                        r_out_total <= '0; r_out_status <= kmss_pkg::ST_FEW;
                        r_state <= S_OUT;
                    end else begin
                        for (int i = 0; i < MAX_SITES; i++) r_idx[i] <= SW'(i);
                        r_best <= kmss_pkg::TOTAL_MAX;
                        r_sum <= '0; r_d <= '0;
                        r_state <= (r_dcnt == '0) ? S_NEXT : S_RD;
                    end
                end
                S_RD: begin
                    // ram read of current demand point
                    r_near <= kmss_pkg::NEAR_INIT;
                    r_j <= '0;
                    r_state <= S_SITE;
                end
                S_SITE: begin
                    if (r_j == r_k) begin
                        r_sum <= w_acc[14] || w_acc[13:0] == 14'h3FFF ? kmss_pkg::TOTAL_MAX
                                 : w_acc[13:0];
                        if (32'(r_d) + 1 >= 32'(r_dcnt)) r_state <= S_NEXT;
                        else begin
                            r_d <= r_d + 1'b1;
                            r_state <= S_RD;
                        end
                    end else begin
                        if (w_dist < r_near) r_near <= w_dist;
                        r_j <= r_j + 1'b1;
                    end
                end
                S_NEXT: begin
                    // cost of this subset is in r_sum
                    if (r_sum < r_best) r_best <= r_sum;
                    r_sum <= '0; r_d <= '0;
                    if (w_moved) begin
                        for (int i = 0; i < MAX_SITES; i++) begin
                            if (i > 32'(w_pos))
                                r_idx[i] <= SW'(32'(r_idx[w_pos]) + 1 + i - 32'(w_pos));
                        end
                        r_idx[w_pos] <= r_idx[w_pos] + 1'b1;
                        r_state <= (r_dcnt == '0) ? S_NEXT : S_RD;
                    end else begin
                        r_out_total <= (r_sum < r_best) ? r_sum : r_best;
                        r_out_status <= kmss_pkg::ST_OK;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_pos <= '0; r_row <= '0; r_col <= '0;
                        r_dcnt <= '0; r_scnt <= '0; r_ovf <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign result.valid = r_out_valid;
    assign result.best_total = r_out_total;
    assign result.status = r_out_status;

    // checks
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_LOAD |-> !grid_cell.ready) else $error("ready while searching");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_scnt) <= MAX_SITES) else $error("site count overflow");
    a_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != kmss_pkg::ST_OK |-> r_out_total == '0)
        else $error("error result with nonzero total");
endmodule
`default_nettype wire

>>> verif/kmss_checker.sv
// grid load predictor and result comparator for the k-median site selection block
`timescale 1ns / 1ps
`default_nettype none
module kmss_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [0:0] i_cfg_index,
    input  wire  [6:0] i_cfg_data,
    kmss_cell_if       grid_cell,
    kmss_result_if     result,
    output int         o_fail_count,
    output int         o_pending
);
    typedef struct packed {
        logic [13:0] best_total;
        logic [1:0]  status;
    } t_selection;

    t_selection  expected_selections[$];
    logic [6:0]  grid_reg;
    logic [4:0]  pick_reg;
    logic [11:0] demand_store [kmss_pkg::MAX_DEMAND_DEF];
    logic [11:0] site_store [kmss_pkg::MAX_SITES_DEF];
    int          demand_num;
    int          site_num;
    logic [11:0] position;
    bit          overflow;

    assign o_pending = expected_selections.size();

    // summed nearest-site distance for one chosen subset
    function automatic int subset_distance(input int picks [16], input int k);
        int sum;
        int near;
        int span;
        int dr;
        int dc;
        int sr;
        int sc;
        sum = 0;
        for (int d = 0; d < demand_num; d++) begin
            dr = demand_store[d][11:6];
            dc = demand_store[d][5:0];
            near = 255;
            for (int j = 0; j < k; j++) begin
                sr = site_store[picks[j]][11:6];
                sc = site_store[picks[j]][5:0];
                span = (dr > sr ? dr - sr : sr - dr) + (dc > sc ? dc - sc : sc - dc);
                if (span < near) near = span;
            end
            sum += near;
            if (sum > kmss_pkg::TOTAL_MAX) sum = kmss_pkg::TOTAL_MAX;
        end
        return sum;
    endfunction

    // lexicographic walk over all subsets, keeping the cheapest
    function automatic int cheapest_total(input int k);
        int picks [16];
        int best;
        int cost;
        int i;
        bit moved;
        best = kmss_pkg::TOTAL_MAX;
        for (int n = 0; n < 16; n++) picks[n] = n;
        forever begin
            cost = subset_distance(picks, k);
            if (cost < best) best = cost;
            moved = 0;
            i = k;
            while (i > 0 && !moved) begin
                i--;
                if (picks[i] < site_num - k + i) begin
                    picks[i]++;
                    for (int j = i + 1; j < k; j++) picks[j] = picks[j-1] + 1;
                    moved = 1;
                end
            end
            if (!moved) break;
        end
        return best;
    endfunction

    // track config, load cells and predict on the last cell
    always @(posedge i_clk) begin
        int g;
        int k;
        t_selection sel;
        logic [11:0] packed_pos;
        if (!i_rst_n) begin
            grid_reg <= 7'd5;
            pick_reg <= 5'd1;
            demand_num = 0;
            site_num = 0;
            position = '0;
            overflow = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == kmss_pkg::REG_GRID) grid_reg <= i_cfg_data;
                else pick_reg <= i_cfg_data[4:0];
            end
            if (grid_cell.valid && grid_cell.ready) begin
                g = (grid_reg < 1) ? 1 : (grid_reg > kmss_pkg::MAX_GRID_DEF) ?
                    kmss_pkg::MAX_GRID_DEF : grid_reg;
                if (position < g * g) begin
                    packed_pos = {6'(position / g), 6'(position % g)};
                    if (grid_cell.cell_code == kmss_pkg::CODE_DEMAND) begin
                        if (demand_num < kmss_pkg::MAX_DEMAND_DEF)
                            demand_store[demand_num++] = packed_pos;
                        else overflow = 1;
                    end else if (grid_cell.cell_code == kmss_pkg::CODE_SITE) begin
                        if (site_num < kmss_pkg::MAX_SITES_DEF)
                            site_store[site_num++] = packed_pos;
                        else overflow = 1;
                    end
                end
                position = position + 12'd1;
                if (grid_cell.last_cell) begin
                    k = (pick_reg < 1) ? 1 : (pick_reg > kmss_pkg::MAX_SITES_DEF) ?
                        kmss_pkg::MAX_SITES_DEF : pick_reg;
                    sel.best_total = '0;
                    if (overflow) sel.status = kmss_pkg::ST_OVF;
                    else if (site_num < k) sel.status = kmss_pkg::ST_FEW;
                    else begin
                        sel.status = kmss_pkg::ST_OK;
                        sel.best_total = 14'(cheapest_total(k));
                    end
                    expected_selections = {expected_selections, sel};
                    demand_num = 0;
                    site_num = 0;
                    position = '0;
                    overflow = 0;
                end
            end
        end
    end

    // compare each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_selection want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else if (result.valid && result.ready) begin
            if (expected_selections.size() == 0) begin
                $display("%0t unexpected result best_total %0d status %0d", $time,
                         result.best_total, result.status);
                o_fail_count <= o_fail_count + 1;
            end else begin
                want = expected_selections.pop_front();
                if (want.best_total !== result.best_total || want.status !== result.status) begin
                    $display("%0t mismatch best_total expected %0d actual %0d", $time,
                             want.best_total, result.best_total);
                    $display("%0t mismatch status expected %0d actual %0d", $time,
                             want.status, result.status);
                    o_fail_count <= o_fail_count + 1;
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> verif/tb_top.sv
// stimulus, clocking and verdict for the k-median site selection block
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    localparam int CYCLE_LIMIT = 4000000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [0:0] i_cfg_index;
    logic [6:0] i_cfg_data;
    int         fail_count;
    int         pending;
    int         cycles;
    int         send_idle_pct;
    int         stall_pct;

    kmss_cell_if   cell_ch();
    kmss_result_if res_ch();

    k_median_site_selection dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .grid_cell(cell_ch), .result(res_ch)
    );

    kmss_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .grid_cell(cell_ch), .result(res_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // clock and inputs known from time zero
    initial begin
        i_clk = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_index = kmss_pkg::REG_GRID;
        i_cfg_data = '0;
        cell_ch.valid = 0;
        cell_ch.cell_code = kmss_pkg::CODE_EMPTY;
        cell_ch.last_cell = 0;
        res_ch.ready = 0;
        send_idle_pct = 0;
        stall_pct = 0;
    end
    always #4 i_clk = ~i_clk;

    // random back-pressure on results
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end
    initial cycles = 0;

    task automatic write_reg(input logic [0:0] idx, input logic [6:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    // one cell transfer with random idle gaps ahead of it
    task automatic send_cell(input logic [1:0] code, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cell_ch.valid <= 0;
            @(posedge i_clk);
        end
        cell_ch.valid <= 1;
        cell_ch.cell_code <= code;
        cell_ch.last_cell <= last;
        @(posedge i_clk);
        while (!cell_ch.ready) @(posedge i_clk);
    endtask

    // wait for all results, then let the block settle before config writes
    task automatic drain;
        cell_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // random grid with capped site and demand counts to bound search time
    task automatic random_grid(input int n, input int site_cap, input int demand_cap);
        int sites;
        int demands;
        int r;
        logic [1:0] code;
        sites = 0;
        demands = 0;
        for (int c = 0; c < n; c++) begin
            r = $urandom_range(0, 9);
            if (r < 2) code = kmss_pkg::CODE_EMPTY;
            else if (r < 4) code = kmss_pkg::CODE_UNUSED;
            else if (r < 7) code = kmss_pkg::CODE_DEMAND;
            else code = kmss_pkg::CODE_SITE;
            if (code == kmss_pkg::CODE_SITE && sites >= site_cap) code = kmss_pkg::CODE_EMPTY;
            if (code == kmss_pkg::CODE_DEMAND && demands >= demand_cap)
                code = kmss_pkg::CODE_UNUSED;
            if (code == kmss_pkg::CODE_SITE) sites++;
            if (code == kmss_pkg::CODE_DEMAND) demands++;
            send_cell(code, c == n - 1);
        end
    endtask

    initial begin
        int g;
        int n;
        int v;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset configuration, full 5x5 grid
        random_grid(25, 6, 20);
        drain();

        // zero registers act as one, cells past the grid are ignored
        write_reg(kmss_pkg::REG_GRID, 7'd0);
        write_reg(kmss_pkg::REG_PICK, 7'd0);
        send_cell(kmss_pkg::CODE_SITE, 0);
        send_cell(kmss_pkg::CODE_DEMAND, 0);
        send_cell(kmss_pkg::CODE_SITE, 1);
        drain();

        // oversize registers clamp, all sixteen sites picked, early end
        write_reg(kmss_pkg::REG_GRID, 7'd127);
        write_reg(kmss_pkg::REG_PICK, 7'd31);
        for (int c = 0; c < 16; c++) send_cell(kmss_pkg::CODE_SITE, 0);
        send_cell(kmss_pkg::CODE_DEMAND, 0);
        send_cell(kmss_pkg::CODE_UNUSED, 0);
        send_cell(kmss_pkg::CODE_DEMAND, 1);
        drain();

        // too few sites
        write_reg(kmss_pkg::REG_GRID, 7'd3);
        write_reg(kmss_pkg::REG_PICK, 7'd3);
        send_cell(kmss_pkg::CODE_SITE, 0);
        send_cell(kmss_pkg::CODE_DEMAND, 0);
        send_cell(kmss_pkg::CODE_SITE, 1);
        drain();

        // site store overflow with all sixteen sites picked
        write_reg(kmss_pkg::REG_GRID, 7'd5);
        write_reg(kmss_pkg::REG_PICK, 7'd16);
        for (int c = 0; c < 17; c++) send_cell(kmss_pkg::CODE_SITE, c == 16);
        drain();

        // demand store overflow
        write_reg(kmss_pkg::REG_GRID, 7'd12);
        write_reg(kmss_pkg::REG_PICK, 7'd1);
        send_cell(kmss_pkg::CODE_SITE, 0);
        for (int c = 0; c < 129; c++) send_cell(kmss_pkg::CODE_DEMAND, c == 128);
        drain();

        // sites but no demand
        write_reg(kmss_pkg::REG_GRID, 7'd3);
        for (int c = 0; c < 9; c++)
            send_cell(c == 4 ? kmss_pkg::CODE_SITE : kmss_pkg::CODE_EMPTY, c == 8);
        drain();

        // largest grid with an early end, a full row of demand points
        write_reg(kmss_pkg::REG_GRID, 7'd64);
        for (int c = 0; c < 128; c++)
            send_cell(c == 0 ? kmss_pkg::CODE_SITE :
                      (c >= 64 ? kmss_pkg::CODE_DEMAND : kmss_pkg::CODE_EMPTY), c == 127);
        drain();

        // random grids over three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 83 : 0;
            stall_pct = (phase == 0) ? 83 : (phase == 1) ? 15 : 0;
            for (int m = 0; m < 6; m++) begin
                if ($urandom_range(0, 2) == 0) begin
                    write_reg(kmss_pkg::REG_GRID, 7'($urandom_range(1, 5)));
                    write_reg(kmss_pkg::REG_PICK, 7'($urandom_range(1, 4)));
                end
                g = $urandom_range(1, 5);
                write_reg(kmss_pkg::REG_GRID, 7'(g));
                n = g * g;
                v = $urandom_range(0, 9);
                if (v == 0) n = $urandom_range(1, n);
                else if (v == 1) n = n + $urandom_range(1, 4);
                random_grid(n, 6, 20);
                drain();
            end
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> k_median_site_selection.f
rtl/core/kmss_pkg.sv
rtl/core/kmss_cell_if.sv
rtl/core/kmss_result_if.sv
rtl/core/kmss_ram.sv
rtl/core/k_median_site_selection.sv
verif/kmss_checker.sv
verif/tb_top.sv
